[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the analog stick conditioner.
// These are clocked property checks that are left out of synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every rising edge outside reset.
`define ACU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("analog stick conditioner: assertion failed");
// The condition must never be true at a rising edge outside reset.
`define ACU_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("analog stick conditioner: forbidden condition seen");
`else
`define ACU_ASSERT(lbl, clk, rst, prop)
`define ACU_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

[design/acu_pkg.sv]
// ---------------------------------------------------------------------------
// acu_pkg
// Types, constants and tables that the conditioner modules share.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package acu_pkg;

   // Input transaction: one raw stick sample in Q1.15.
   typedef struct packed {
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
   } req_payload_type;

   // Result transaction.
   typedef struct packed {
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic [15:0]        stick_angle;
      logic [15:0]        stick_magnitude;
      logic               is_calibrated;
   } rsp_payload_type;

   // Status that each iterative unit reports to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_DEAD_ZONE_MODE    = 2'd0;
   localparam logic [1:0] CSR_INITIAL_DEAD_ZONE = 2'd1;
   localparam logic [1:0] CSR_FINAL_DEAD_ZONE   = 2'd2;

   // Register reset values.
   localparam logic        RST_DEAD_ZONE_MODE    = 1'b1;
   localparam logic [15:0] RST_INITIAL_DEAD_ZONE = 16'd19661;
   localparam logic [15:0] RST_FINAL_DEAD_ZONE   = 16'd13107;

   // 0.99 of full scale, rounded up.
   localparam logic signed [15:0] CAL_LEVEL = 16'sd32441;

   // Number of steps in every iterative unit.
   localparam int unsigned UNIT_STEPS = 16;

   // Arctangent of 2^-i in units of 2^-24 turn.
   function automatic logic [23:0] atan_turn(input logic [3:0] idx);
      logic [23:0] val;
      case (idx)
         4'd0:    val = 24'd2097152;
         4'd1:    val = 24'd1238021;
         4'd2:    val = 24'd654136;
         4'd3:    val = 24'd332050;
         4'd4:    val = 24'd166669;
         4'd5:    val = 24'd83416;
         4'd6:    val = 24'd41718;
         4'd7:    val = 24'd20860;
         4'd8:    val = 24'd10430;
         4'd9:    val = 24'd5215;
         4'd10:   val = 24'd2608;
         4'd11:   val = 24'd1304;
         4'd12:   val = 24'd652;
         4'd13:   val = 24'd326;
         4'd14:   val = 24'd163;
         default: val = 24'd81;
      endcase
      return val;
   endfunction

endpackage

[design/analog_stick_conditioner_unit.sv]
// ---------------------------------------------------------------------------
// analog_stick_conditioner_unit
// Dead zone, magnitude limiting and direction for one analog stick sample.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  raw_x, raw_y
//   rsp_      out        rsp_valid/rsp_stall  stick_x/y, angle, magnitude, flag
//   csr_      in         csr_we               csr_index, csr_wdata
//
// A sample passes twice through the shared sixteen-step divider for the
// dead zone, and twice more when the vector is longer than 1.0 and must
// be scaled down; root and CORDIC run side by side.
// Reset is synchronous and clears the control state, configuration and
// calibration registers; the working and result data are not reset.
// A stalled result waits in the output register; the next sample is
// accepted meanwhile but its result is held until the first is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module analog_stick_conditioner_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  acu_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output acu_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);
   import acu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DZ_X,
      ST_DZ_Y,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_SC_X,
      ST_SC_Y,
      ST_OUT
   } state_type;

   state_type state_ff;

   // Configuration registers.
   logic        cfg_mode_ff;
   logic [15:0] cfg_initial_ff;
   logic [15:0] cfg_final_ff;

   // Calibration state.
   logic               cal_ff;
   logic signed [15:0] min_x_ff, max_x_ff, min_y_ff, max_y_ff;
   logic signed [15:0] last_x_ff, last_y_ff;
   logic signed [15:0] min_x_in, max_x_in, min_y_in, max_y_in;
   logic               cal_in;

   // Per-transaction working registers.
   logic signed [15:0] raw_x_ff, raw_y_ff;
   logic               mode_ff;
   logic [15:0]        dz_ff;
   logic [16:0]        ax_ff, ay_ff;
   logic               sx_ff, sy_ff;
   logic [31:0]        s_ff;
   logic [15:0]        root_ff;
   logic [15:0]        ang_ff;
   logic [15:0]        qx_ff, qy_ff;
   logic               root_got_ff, ang_got_ff;
   logic               div_start_ff, unit_start_ff;
   logic               div_start_in, unit_start_in;
   logic               units_done;
   logic               div_phase;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   // Shared unit connections.
   unit_status_type div_stat, sqrt_stat, cordic_stat;
   logic [31:0]     div_numer;
   logic [16:0]     div_denom;
   logic [15:0]     div_quot;
   logic [15:0]     sqrt_root;
   logic [15:0]     cordic_angle;

   // Dead zone operands.
   logic signed [15:0] sel_raw;
   logic [16:0]        abs_v;
   logic [16:0]        dz_a;
   logic [16:0]        dz_den;
   logic [16:0]        dz_diff;
   logic               dz_zero;
   logic [16:0]        dz_value;
   logic [31:0]        dz_numer;
   logic [16:0]        sc_mag;
   logic               sc_phase;

   // Squaring.
   logic [16:0] mul_op;
   logic [33:0] mul_prod;

   // Result assembly.
   logic               scale;
   logic signed [16:0] vec_x, vec_y;
   logic [16:0]        out_mx, out_my;
   logic signed [15:0] out_x, out_y;

   // Dead zone: 2|v| in Q0.16, rounded quotient of the excess.
   always_comb begin
      sel_raw  = (state_ff == ST_DZ_Y) ? raw_y_ff : raw_x_ff;
      abs_v    = sel_raw[15] ? 17'(-{sel_raw[15], sel_raw}) : {1'b0, sel_raw};
      dz_a     = {abs_v[15:0], 1'b0};
      dz_zero  = dz_a <= {1'b0, dz_ff};
      dz_den   = 17'h1_0000 - {1'b0, dz_ff};
      dz_diff  = dz_a - {1'b0, dz_ff};
      dz_numer = {dz_diff, 15'b0} + {16'b0, dz_den[16:1]};
      if (!mode_ff) begin
         dz_value = abs_v;
      end else if (dz_zero) begin
         dz_value = '0;
      end else begin
         dz_value = {1'b0, div_quot};
      end
   end

   // Divider operand selection: dead zone or magnitude scaling.
   always_comb begin
      sc_phase = (state_ff == ST_SC_X) || (state_ff == ST_SC_Y);
      sc_mag   = (state_ff == ST_SC_Y) ? ay_ff : ax_ff;
      if (sc_phase) begin
         div_numer = {sc_mag[16:0], 15'b0};
         div_denom = {1'b0, root_ff};
      end else begin
         div_numer = dz_numer;
         div_denom = dz_den;
      end
   end

   // One multiplier squares each axis in turn.
   assign mul_op   = (state_ff == ST_SQ_Y) ? ay_ff : ax_ff;
   assign mul_prod = mul_op * mul_op;

   // Calibration tracks the previous result before this sample.
   always_comb begin
      max_x_in = (last_x_ff > max_x_ff) ? last_x_ff : max_x_ff;
      min_x_in = (last_x_ff < min_x_ff) ? last_x_ff : min_x_ff;
      max_y_in = (last_y_ff > max_y_ff) ? last_y_ff : max_y_ff;
      min_y_in = (last_y_ff < min_y_ff) ? last_y_ff : min_y_ff;
      cal_in   = (max_x_in >= CAL_LEVEL) && (min_x_in <= -CAL_LEVEL) &&
                 (max_y_in >= CAL_LEVEL) && (min_y_in <= -CAL_LEVEL);
   end

   // Signed axis values and the limited output vector.
   always_comb begin
      vec_x  = sx_ff ? 17'(-ax_ff) : ax_ff;
      vec_y  = sy_ff ? 17'(-ay_ff) : ay_ff;
      scale  = s_ff > 32'h4000_0000;
      out_mx = scale ? {1'b0, qx_ff} : ax_ff;
      out_my = scale ? {1'b0, qy_ff} : ay_ff;
      if (!sx_ff && out_mx[15]) begin
         out_x = 16'sh7FFF;
      end else begin
         out_x = 16'(sx_ff ? 17'(-out_mx) : out_mx);
      end
      if (!sy_ff && out_my[15]) begin
         out_y = 16'sh7FFF;
      end else begin
         out_y = 16'(sy_ff ? 17'(-out_my) : out_my);
      end
   end

   // Start pulses for the shared units.
   always_comb begin
      units_done = (root_got_ff || sqrt_stat.done) && (ang_got_ff || cordic_stat.done);
      case (state_ff)
         ST_IDLE:          div_start_in = req_valid;
         ST_DZ_X, ST_SC_X: div_start_in = div_stat.done;
         ST_ROOT:          div_start_in = units_done && scale;
         default:          div_start_in = 1'b0;
      endcase
      unit_start_in = (state_ff == ST_SQ_Y);
   end

   // Sequencer, configuration and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cfg_mode_ff    <= RST_DEAD_ZONE_MODE;
         cfg_initial_ff <= RST_INITIAL_DEAD_ZONE;
         cfg_final_ff   <= RST_FINAL_DEAD_ZONE;
         cal_ff         <= 1'b0;
         min_x_ff       <= '0;
         max_x_ff       <= '0;
         min_y_ff       <= '0;
         max_y_ff       <= '0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         div_start_ff   <= 1'b0;
         unit_start_ff  <= 1'b0;
         root_got_ff    <= 1'b0;
         ang_got_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         div_start_ff  <= div_start_in;
         unit_start_ff <= unit_start_in;

         if (csr_we) begin
            case (csr_index)
               CSR_DEAD_ZONE_MODE:    cfg_mode_ff    <= csr_wdata[0];
               CSR_INITIAL_DEAD_ZONE: cfg_initial_ff <= csr_wdata;
               CSR_FINAL_DEAD_ZONE:   cfg_final_ff   <= csr_wdata;
               default:               ;
            endcase
         end

         // A taken result frees the output register unless a new one lands.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  raw_x_ff     <= req_payload.raw_x;
                  raw_y_ff     <= req_payload.raw_y;
                  mode_ff      <= cfg_mode_ff;
                  dz_ff        <= cal_ff ? cfg_final_ff : cfg_initial_ff;
                  if (!cal_ff) begin
                     min_x_ff <= min_x_in;
                     max_x_ff <= max_x_in;
                     min_y_ff <= min_y_in;
                     max_y_ff <= max_y_in;
                     cal_ff   <= cal_in;
                  end
                  state_ff     <= ST_DZ_X;
               end
            end
            ST_DZ_X: begin
               if (div_stat.done) begin
                  ax_ff        <= dz_value;
                  sx_ff        <= raw_x_ff[15];
                  state_ff     <= ST_DZ_Y;
               end
            end
            ST_DZ_Y: begin
               if (div_stat.done) begin
                  ay_ff    <= dz_value;
                  sy_ff    <= raw_y_ff[15];
                  state_ff <= ST_SQ_X;
               end
            end
            ST_SQ_X: begin
               s_ff     <= mul_prod[31:0];
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               s_ff          <= s_ff + mul_prod[31:0];
               root_got_ff   <= 1'b0;
               ang_got_ff    <= 1'b0;
               state_ff      <= ST_ROOT;
            end
            ST_ROOT: begin
               // Root and direction run together; wait for both.
               if (sqrt_stat.done) begin
                  root_ff     <= sqrt_root;
                  root_got_ff <= 1'b1;
               end
               if (cordic_stat.done) begin
                  ang_ff     <= cordic_angle;
                  ang_got_ff <= 1'b1;
               end
               if (units_done) begin
                  if (scale) begin
                     state_ff <= ST_SC_X;
                  end else begin
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_SC_X: begin
               if (div_stat.done) begin
                  qx_ff        <= div_quot;
                  state_ff     <= ST_SC_Y;
               end
            end
            ST_SC_Y: begin
               if (div_stat.done) begin
                  qy_ff    <= div_quot;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!(rsp_valid_ff && rsp_stall)) begin
                  rsp_ff.stick_x         <= out_x;
                  rsp_ff.stick_y         <= out_y;
                  rsp_ff.stick_angle     <= ang_ff;
                  rsp_ff.stick_magnitude <= scale ? 16'h8000 : root_ff;
                  rsp_ff.is_calibrated   <= cal_ff;
                  last_x_ff              <= out_x;
                  last_y_ff              <= out_y;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   acu_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_ff),
      .numer  (div_numer),
      .denom  (div_denom),
      .status (div_stat),
      .quot   (div_quot)
   );

   acu_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start_ff),
      .radicand (s_ff),
      .status   (sqrt_stat),
      .root     (sqrt_root)
   );

   acu_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (unit_start_ff),
      .vec_x  (vec_x),
      .vec_y  (vec_y),
      .status (cordic_stat),
      .angle  (cordic_angle)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // States in which the sequencer waits on the divider.
   assign div_phase = (state_ff == ST_DZ_X) || (state_ff == ST_DZ_Y) ||
                      (state_ff == ST_SC_X) || (state_ff == ST_SC_Y);

   // Calibration, once reached, is never lost.
   `ACU_ASSERT(a_cal_sticky, clock, reset, cal_ff |=> cal_ff)
   // The reported magnitude never exceeds 1.0.
   `ACU_ASSERT(a_mag_limit, clock, reset, rsp_valid_ff |-> (rsp_ff.stick_magnitude <= 16'h8000))
   // The divider only finishes while the sequencer waits for it.
   `ACU_ASSERT_NEVER(a_div_owner, clock, reset, div_stat.done && !div_phase)

endmodule

[design/acu_div.sv]
// ---------------------------------------------------------------------------
// acu_div
// Restoring divider, one quotient bit per cycle, sixteen quotient bits.
// The caller guarantees that the quotient fits in sixteen bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acu_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              numer,
   input  logic [16:0]              denom,
   output acu_pkg::unit_status_type status,
   output logic [15:0]              quot
);
   import acu_pkg::*;

   logic [16:0] rem_ff;
   logic [15:0] num_ff;
   logic [16:0] den_ff;
   logic [15:0] quot_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [17:0] trial;
   logic        fits;

   // Bring down the next numerator bit and try the subtraction.
   assign trial = {rem_ff, num_ff[15]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= {1'b0, numer[31:16]};
            num_ff  <= numer[15:0];
            den_ff  <= denom;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= 17'(trial - {1'b0, den_ff});
            end else begin
               rem_ff <= trial[16:0];
            end
            num_ff  <= {num_ff[14:0], 1'b0};
            quot_ff <= {quot_ff[14:0], fits};
            cnt_ff  <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(UNIT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;

endmodule

[design/acu_sqrt.sv]
// ---------------------------------------------------------------------------
// acu_sqrt
// Integer square root, two radicand bits per cycle, sixteen root bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acu_sqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              radicand,
   output acu_pkg::unit_status_type status,
   output logic [15:0]              root
);
   import acu_pkg::*;

   logic [31:0] rem_ff;
   logic [31:0] res_ff;
   logic [31:0] bit_ff;
   logic [3:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [32:0] trial;
   logic        fits;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign fits  = {1'b0, rem_ff} >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= radicand;
            res_ff  <= '0;
            bit_ff  <= 32'h4000_0000;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= 32'({1'b0, rem_ff} - trial);
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(UNIT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = res_ff[15:0];

endmodule

[design/acu_cordic.sv]
// ---------------------------------------------------------------------------
// acu_cordic
// Vectoring CORDIC, one rotation per cycle, giving the stick direction as a
// fraction of a turn measured from negative y towards positive x.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module acu_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [16:0]       vec_x,
   input  logic signed [16:0]       vec_y,
   output acu_pkg::unit_status_type status,
   output logic [15:0]              angle
);
   import acu_pkg::*;

   logic signed [26:0] u_ff;
   logic signed [26:0] w_ff;
   logic [23:0]        z_ff;
   logic [3:0]         cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic signed [26:0] u_init;
   logic signed [26:0] w_init;
   logic signed [26:0] du;
   logic signed [26:0] dw;
   logic [23:0]        z_round;

   // Start vector is (-y, x) scaled by 256.
   assign w_init = {{10{vec_x[16]}}, vec_x} <<< 8;
   assign u_init = -({{10{vec_y[16]}}, vec_y} <<< 8);

   assign du = w_ff >>> cnt_ff;
   assign dw = u_ff >>> cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // Fold the left half plane over with a half turn offset.
            if (u_init[26]) begin
               u_ff <= -u_init;
               w_ff <= -w_init;
               z_ff <= 24'h80_0000;
            end else begin
               u_ff <= u_init;
               w_ff <= w_init;
               z_ff <= '0;
            end
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // Once the vector lies on the axis the remaining steps hold.
            if (w_ff != '0) begin
               if (!w_ff[26]) begin
                  u_ff <= u_ff + du;
                  w_ff <= w_ff - dw;
                  z_ff <= z_ff + atan_turn(cnt_ff);
               end else begin
                  u_ff <= u_ff - du;
                  w_ff <= w_ff + dw;
                  z_ff <= z_ff - atan_turn(cnt_ff);
               end
            end
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(UNIT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Round half up to 2^-16 turn; the full turn wraps away.
   assign z_round = z_ff + 24'd128;

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign angle       = z_round[23:8];

endmodule
